>>> rtl/core/fgl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FONTX2 glyph locator package
// Field widths, register indexes, offset constants, lead byte ranges and the table entry type.
// ----------------------------------------------------------------------------
package fgl_pkg;

   localparam int CODE_W      = 16;
   localparam int DIM_W       = 6;
   localparam int COUNT_W     = 8;
   localparam int BYTES_W     = 8;
   localparam int OFFSET_W    = 32;
   localparam int PROD_W      = 24;
   localparam int INDEX_W     = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_COUNT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_PRESENT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_PRESENT = 3'd6;

   // Header sizes in front of the glyph bitmaps.
   localparam logic [OFFSET_W-1:0] HALF_BASE = 32'd17;
   localparam logic [OFFSET_W-1:0] FULL_BASE = 32'd18;

   // Lead byte ranges of full-width codes.
   localparam logic [7:0] LEAD_LO_FIRST = 8'h80;
   localparam logic [7:0] LEAD_LO_LAST  = 8'h9F;
   localparam logic [7:0] LEAD_HI_FIRST = 8'hE0;
   localparam logic [7:0] LEAD_HI_LAST  = 8'hFC;

   typedef struct packed {
      logic [CODE_W-1:0] first_code;
      logic [CODE_W-1:0] last_code;
   } block_entry_type;

   function automatic logic lead_is_full(input logic [CODE_W-1:0] code);
      logic [7:0] lead;
      lead = code[CODE_W-1:8];
      return lead inside {[LEAD_LO_FIRST:LEAD_LO_LAST], [LEAD_HI_FIRST:LEAD_HI_LAST]};
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/fgl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fgl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/fontx2_glyph_locator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FONTX2 glyph locator core
// Locates glyph bitmaps in FONTX2 font memory from a character code.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. A write beat
// (req_mode 0) stores one code block of the full-width table in the same
// cycle and returns nothing; busy stays low. A lookup beat raises busy
// while it runs and then places one result on the rsp_ ports for exactly
// one cycle, marked by rsp_valid; the receiver cannot stall it, so it must
// take the beat in that cycle. A half-width lookup passes through the
// BYTES, MUL and FINISH states, skipping MUL when the half-width font is
// absent. A full-width lookup scans the block table through one memory read
// port, one entry per cycle, over at most n entries, where n is block_count
// limited to MAX_BLOCKS; the scan stops at the first matching block, an
// empty table ends it without a table read and an absent full-width font
// skips it. The next command may be issued in the cycle that rsp_valid is high.
// Configuration writes on the csr_ channel are always ready and must be made
// while no lookup is in flight. The block table has no reset value: every
// entry below block_count must be written before a full-width lookup.
// ----------------------------------------------------------------------------
module fontx2_glyph_locator_core
   import fgl_pkg::*;
#(
   parameter int MAX_BLOCKS    = 128,
   parameter int MAX_GLYPH_DIM = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Command channel.
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_mode,
   input  wire logic [INDEX_W-1:0]     req_block_index,
   input  wire logic [CODE_W-1:0]      req_range_start,
   input  wire logic [CODE_W-1:0]      req_range_end,
   input  wire logic [CODE_W-1:0]      req_char_code,
   // Result channel.
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic                        rsp_is_full_width,
   output logic [OFFSET_W-1:0]         rsp_glyph_offset,
   output logic [BYTES_W-1:0]          rsp_glyph_bytes,
   output logic [DIM_W-1:0]            rsp_advance_width,
   // Configuration channel.
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BYTES  = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_GLYPH_DIM);

   // Configuration registers.
   logic [DIM_W-1:0]   full_width_ff, full_height_ff, half_width_ff, half_height_ff;
   logic [COUNT_W-1:0] block_count_ff;
   logic               full_present_ff, half_present_ff;

   // Sequencer state.
   logic [2:0]          state_ff, state_in;
   logic [CODE_W-1:0]   code_ff;
   logic                full_ff;
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [CW-1:0]       limit_ff, limit_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic                pending_ff, pending_in;
   logic [CODE_W-1:0]   count_ff, count_in;
   logic [CODE_W-1:0]   operand_ff, operand_in;
   logic [OFFSET_W-1:0] base_ff, base_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                hit_ff, hit_in;

   // Result registers.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_full_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [BYTES_W-1:0]  rsp_bytes_ff;
   logic [DIM_W-1:0]    rsp_width_ff;

   // Table memory signals.
   logic                tbl_wr_en;
   logic [AW+INDEX_W-1:0] tbl_wr_wide;
   block_entry_type     tbl_wr_data;
   logic                tbl_rd_en;
   block_entry_type     tbl_rd_data;

   logic accept;
   logic lookup_start;

   // Helper values for the bytes computation.
   logic               cur_full;
   logic [DIM_W-1:0]   raw_width, raw_height, sat_width, sat_height;
   logic [DIM_W:0]     width_round;
   logic [8:0]         bytes_wide;
   logic [8:0]         count_wide;

   // Scan compare.
   logic               in_block;
   logic [CODE_W-1:0]  block_span;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign lookup_start = accept && req_mode;

   // A write beat goes straight into the table; indexes past the table are
   // dropped.
   assign tbl_wr_wide = {{AW{1'b0}}, req_block_index};
   assign tbl_wr_en   = accept && !req_mode &&
                        ({1'b0, tbl_wr_wide} < (AW + INDEX_W + 1)'(MAX_BLOCKS));
   assign tbl_wr_data = '{first_code: req_range_start, last_code: req_range_end};
   assign tbl_rd_en   = (state_ff == ST_SCAN) && (issue_ff < limit_ff);

   fgl_ram #(
      .WIDTH ($bits(block_entry_type)),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_wide[AW-1:0]),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (tbl_rd_data)
   );

   // Glyph size of the class that the code falls in, limited to the largest
   // supported dimension.
   always_comb begin
      cur_full    = lead_is_full(req_char_code);
      raw_width   = cur_full ? full_width_ff : half_width_ff;
      raw_height  = cur_full ? full_height_ff : half_height_ff;
      sat_width   = (raw_width > DIM_MAX) ? DIM_MAX : raw_width;
      sat_height  = (raw_height > DIM_MAX) ? DIM_MAX : raw_height;
      width_round = {1'b0, width_ff} + (DIM_W + 1)'(7);
      bytes_wide  = 9'(width_round[DIM_W:3]) * 9'(height_ff);
      count_wide  = {1'b0, block_count_ff};
   end

   always_comb begin
      in_block   = (code_ff >= tbl_rd_data.first_code) &&
                   (code_ff <= tbl_rd_data.last_code);
      block_span = tbl_rd_data.last_code - tbl_rd_data.first_code;
   end

   // Sequencer. The scan issues one table read per cycle and checks the
   // entry read in the cycle before, so the read latency is hidden.
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      bytes_in     = bytes_ff;
      limit_in     = limit_ff;
      issue_in     = issue_ff;
      pending_in   = 1'b0;
      count_in     = count_ff;
      operand_in   = operand_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (lookup_start) begin
               width_in  = sat_width;
               height_in = sat_height;
               hit_in    = 1'b0;
               state_in  = ST_BYTES;
            end
         end
         ST_BYTES: begin
            bytes_in   = bytes_wide[BYTES_W-1:0];
            limit_in   = (count_wide > 9'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_wide);
            issue_in   = '0;
            count_in   = '0;
            operand_in = code_ff;
            if (full_ff) begin
               base_in  = FULL_BASE + (OFFSET_W'(limit_in) << 2);
               state_in = full_present_ff ? ST_SCAN : ST_FINISH;
            end else begin
               base_in  = HALF_BASE;
               hit_in   = half_present_ff;
               state_in = half_present_ff ? ST_MUL : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (tbl_rd_en) begin
               issue_in = issue_ff + CW'(1);
            end
            pending_in = tbl_rd_en;
            if (pending_ff) begin
               if (in_block) begin
                  operand_in = count_ff + (code_ff - tbl_rd_data.first_code);
                  hit_in     = 1'b1;
                  state_in   = ST_MUL;
               end else begin
                  count_in = count_ff + block_span + CODE_W'(1);
               end
            end else if (issue_ff == limit_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(operand_ff) * PROD_W'(bytes_ff);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pending_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         full_width_ff   <= DIM_W'(16);
         full_height_ff  <= DIM_W'(16);
         half_width_ff   <= DIM_W'(8);
         half_height_ff  <= DIM_W'(16);
         block_count_ff  <= '0;
         full_present_ff <= 1'b0;
         half_present_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FULL_WIDTH:   full_width_ff   <= csr_data[DIM_W-1:0];
               REG_FULL_HEIGHT:  full_height_ff  <= csr_data[DIM_W-1:0];
               REG_HALF_WIDTH:   half_width_ff   <= csr_data[DIM_W-1:0];
               REG_HALF_HEIGHT:  half_height_ff  <= csr_data[DIM_W-1:0];
               REG_BLOCK_COUNT:  block_count_ff  <= csr_data[COUNT_W-1:0];
               REG_FULL_PRESENT: full_present_ff <= csr_data[0];
               REG_HALF_PRESENT: half_present_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      if (lookup_start) begin
         code_ff <= req_char_code;
         full_ff <= cur_full;
      end
      width_ff   <= width_in;
      height_ff  <= height_in;
      bytes_ff   <= bytes_in;
      limit_ff   <= limit_in;
      issue_ff   <= issue_in;
      count_ff   <= count_in;
      operand_ff <= operand_in;
      base_ff    <= base_in;
      prod_ff    <= prod_in;
      hit_ff     <= hit_in;
      if (state_ff == ST_FINISH) begin
         rsp_found_ff  <= hit_ff;
         rsp_full_ff   <= full_ff;
         rsp_offset_ff <= hit_ff ? (base_ff + OFFSET_W'(prod_ff)) : '0;
         rsp_bytes_ff  <= hit_ff ? bytes_ff : '0;
         rsp_width_ff  <= hit_ff ? width_ff : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_is_full_width = rsp_full_ff;
   assign rsp_glyph_offset  = rsp_offset_ff;
   assign rsp_glyph_bytes   = rsp_bytes_ff;
   assign rsp_advance_width = rsp_width_ff;

endmodule
`default_nettype wire

>>> verif/tb_fontx2_glyph_locator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FONTX2 glyph locator core testbench
// Loads the full-width code block table, walks the block through a series of
// glyph size, block count and font presence settings, and checks every lookup
// result field by field against a scoreboard fed by a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_fontx2_glyph_locator_core;
   import fgl_pkg::*;

   localparam int MAX_BLOCKS    = 128;
   localparam int MAX_GLYPH_DIM = 32;
   // Idle cycles allowed after the scoreboard empties before the next queued
   // beat. Table writes finish in the cycle they are taken, so a few suffice.
   localparam int SETTLE_CYCLES = 8;
   // Roughly 1100 beats, each with its lookup time and any idle gap before it,
   // plus drains, stay far below this limit.
   localparam int LIMIT_CYCLES  = 800000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 110;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      OP_CMD,
      OP_CSR,
      OP_DRAIN
   } op_kind_type;

   // One entry of the stimulus queue. A drain entry holds the driver until
   // every predicted result has come back and the block has settled.
   typedef struct {
      op_kind_type              kind;
      int unsigned              gap_pct;
      logic                     mode;
      logic [INDEX_W-1:0]       block_index;
      logic [CODE_W-1:0]        range_start;
      logic [CODE_W-1:0]        range_end;
      logic [CODE_W-1:0]        char_code;
      logic [CSR_INDEX_W-1:0]   reg_index;
      logic [CSR_DATA_W-1:0]    reg_data;
   } op_type;

   typedef struct packed {
      logic                found;
      logic                is_full;
      logic [OFFSET_W-1:0] offset;
      logic [BYTES_W-1:0]  glyph_bytes;
      logic [DIM_W-1:0]    advance;
   } glyph_loc_type;

   // Clock, reset and DUT ports. Every input starts at a known value.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_mode = MODE_WRITE;
   logic [INDEX_W-1:0]     req_block_index = '0;
   logic [CODE_W-1:0]      req_range_start = '0;
   logic [CODE_W-1:0]      req_range_end = '0;
   logic [CODE_W-1:0]      req_char_code = '0;
   logic                   rsp_valid;
   logic                   rsp_found;
   logic                   rsp_is_full_width;
   logic [OFFSET_W-1:0]    rsp_glyph_offset;
   logic [BYTES_W-1:0]     rsp_glyph_bytes;
   logic [DIM_W-1:0]       rsp_advance_width;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor state: a private copy of the registers and the block table,
   // updated at the edge where each beat is accepted.
   logic [DIM_W-1:0]       reg_full_w;
   logic [DIM_W-1:0]       reg_full_h;
   logic [DIM_W-1:0]       reg_half_w;
   logic [DIM_W-1:0]       reg_half_h;
   logic [COUNT_W-1:0]     reg_block_count;
   logic                   reg_full_present;
   logic                   reg_half_present;
   block_entry_type        code_blocks [MAX_BLOCKS];

   // What the stimulus generator believes the table will hold when its
   // lookups are issued; used only to aim codes at real blocks.
   block_entry_type        plan_blocks [MAX_BLOCKS];
   int unsigned            plan_count;

   op_type                 op_q [$];
   glyph_loc_type          expected_locs [$];
   op_type                 cur_op;

   // Driver pacing state.
   int unsigned            gap_left;
   logic                   gap_rolled;
   logic                   draining;
   int unsigned            settle_left;
   logic                   stim_done = 1'b0;

   // Bookkeeping for the summary and the verdict.
   int unsigned            cycle_count = 0;
   int unsigned            mismatches = 0;
   int unsigned            lookups_taken = 0;
   int unsigned            writes_taken = 0;
   int unsigned            regs_taken = 0;
   int unsigned            results_seen = 0;
   int unsigned            located_seen = 0;
   int unsigned            full_seen = 0;

   // Idle probability in percent for each random phase. The second phase runs
   // without gaps, and the last one is gap free as well.
   int unsigned            gap_plan [RANDOM_PHASES] = '{25, 0, 40, 10, 60, 25, 15, 0};

   fontx2_glyph_locator_core #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_block_index   (req_block_index),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_is_full_width (rsp_is_full_width),
      .rsp_glyph_offset  (rsp_glyph_offset),
      .rsp_glyph_bytes   (rsp_glyph_bytes),
      .rsp_advance_width (rsp_advance_width),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // A lead byte in 0x80-0x9F or 0xE0-0xFC marks a two-byte, full-width code.
   function automatic logic is_kanji_lead(input logic [7:0] lead);
      return (lead >= LEAD_LO_FIRST && lead <= LEAD_LO_LAST) ||
             (lead >= LEAD_HI_FIRST && lead <= LEAD_HI_LAST);
   endfunction

   // Predicts the result of one lookup from the current register and table
   // copies. Full-width codes walk the blocks in order, summing the glyphs of
   // every block passed with a 16-bit wrapping counter, so a reversed block
   // contributes (last - first + 1) mod 65536.
   function automatic glyph_loc_type locate_glyph(input logic [CODE_W-1:0] code);
      glyph_loc_type loc;
      logic          full;
      int unsigned   w;
      int unsigned   h;
      int unsigned   nbytes;
      int unsigned   n;
      int unsigned   passed;
      int unsigned   blk_lo;
      int unsigned   blk_hi;
      int unsigned   j;
      full = is_kanji_lead(code[CODE_W-1:8]);
      w = full ? reg_full_w : reg_half_w;
      h = full ? reg_full_h : reg_half_h;
      if (w > MAX_GLYPH_DIM) w = MAX_GLYPH_DIM;
      if (h > MAX_GLYPH_DIM) h = MAX_GLYPH_DIM;
      nbytes = ((w + 7) / 8) * h;
      loc = '0;
      loc.is_full = full;
      if (full && reg_full_present) begin
         // Counts above the table size are clamped, for the scan and the
         // header term alike.
         n = (reg_block_count > MAX_BLOCKS) ? MAX_BLOCKS : reg_block_count;
         passed = 0;
         for (j = 0; j < n && !loc.found; j++) begin
            blk_lo = code_blocks[j].first_code;
            blk_hi = code_blocks[j].last_code;
            if (code >= blk_lo && code <= blk_hi) begin
               passed = (passed + code - blk_lo) & 32'hFFFF;
               loc.found = 1'b1;
               loc.offset = FULL_BASE + 4 * n + passed * nbytes;
            end else begin
               passed = (passed + blk_hi - blk_lo + 1) & 32'hFFFF;
            end
         end
      end else if (!full && reg_half_present) begin
         loc.found = 1'b1;
         loc.offset = HALF_BASE + code * nbytes;
      end
      // A miss or an absent font reports zero size and width.
      if (loc.found) begin
         loc.glyph_bytes = nbytes[BYTES_W-1:0];
         loc.advance = w[DIM_W-1:0];
      end
      return loc;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus queue builders. They only append to the queue; the driver
   // decides when each beat goes out.
   // ------------------------------------------------------------------------
   task automatic queue_lookup(input logic [CODE_W-1:0] code, input int unsigned pct);
      op_type op;
      op = '{kind: OP_CMD, default: '0};
      op.kind = OP_CMD;
      op.gap_pct = pct;
      op.mode = MODE_LOOKUP;
      // Write-only fields carry noise on lookups; the block must ignore them.
      op.block_index = INDEX_W'($urandom_range(0, MAX_BLOCKS - 1));
      op.range_start = CODE_W'($urandom_range(0, 65535));
      op.range_end = CODE_W'($urandom_range(0, 65535));
      op.char_code = code;
      op_q.push_back(op);
   endtask

   task automatic queue_block_write(input logic [INDEX_W-1:0] idx,
                                    input logic [CODE_W-1:0] lo,
                                    input logic [CODE_W-1:0] hi,
                                    input int unsigned pct);
      op_type op;
      op = '{kind: OP_CMD, default: '0};
      op.kind = OP_CMD;
      op.gap_pct = pct;
      op.mode = MODE_WRITE;
      op.block_index = idx;
      op.range_start = lo;
      op.range_end = hi;
      op.char_code = CODE_W'($urandom_range(0, 65535));
      op_q.push_back(op);
      plan_blocks[idx] = '{first_code: lo, last_code: hi};
   endtask

   task automatic queue_drain();
      op_type op;
      op = '{kind: OP_DRAIN, default: '0};
      op.kind = OP_DRAIN;
      op_q.push_back(op);
   endtask

   // Registers are only touched once the block is idle, so every setting
   // starts with a drain. All seven registers are rewritten each time.
   task automatic queue_setting(input int unsigned pct,
                                input logic [7:0] fw, input logic [7:0] fh,
                                input logic [7:0] hw, input logic [7:0] hh,
                                input logic [7:0] count,
                                input logic [7:0] fp, input logic [7:0] hp);
      op_type      op;
      logic [7:0]  vals [7];
      int unsigned k;
      vals = '{fw, fh, hw, hh, count, fp, hp};
      queue_drain();
      for (k = 0; k < 7; k++) begin
         op = '{kind: OP_CSR, default: '0};
         op.kind = OP_CSR;
         op.gap_pct = pct;
         op.reg_data = vals[k];
         case (k)
            0: op.reg_index = REG_FULL_WIDTH;
            1: op.reg_index = REG_FULL_HEIGHT;
            2: op.reg_index = REG_HALF_WIDTH;
            3: op.reg_index = REG_HALF_HEIGHT;
            4: op.reg_index = REG_BLOCK_COUNT;
            5: op.reg_index = REG_FULL_PRESENT;
            default: op.reg_index = REG_HALF_PRESENT;
         endcase
         op_q.push_back(op);
      end
      plan_count = (count > MAX_BLOCKS) ? MAX_BLOCKS : count;
   endtask

   // Random setting: mostly legal glyph sizes with the odd out-of-range or
   // zero dimension, mostly short tables with some counts beyond the table,
   // and fonts present most of the time. Upper data bits carry noise.
   task automatic queue_random_setting(input int unsigned pct);
      logic [7:0]  dims [4];
      logic [7:0]  count;
      int unsigned sel;
      int unsigned k;
      for (k = 0; k < 4; k++) begin
         if ($urandom_range(0, 7) == 0) dims[k] = 8'($urandom_range(0, 255));
         else dims[k] = 8'($urandom_range(1, MAX_GLYPH_DIM));
      end
      sel = $urandom_range(0, 19);
      if (sel < 12) count = 8'($urandom_range(1, 24));
      else if (sel < 15) count = 8'd0;
      else if (sel < 18) count = 8'($urandom_range(MAX_BLOCKS, 255));
      else count = 8'($urandom_range(25, MAX_BLOCKS - 1));
      queue_setting(pct, dims[0], dims[1], dims[2], dims[3], count,
                    {7'($urandom_range(0, 127)), 1'($urandom_range(0, 4) != 0)},
                    {7'($urandom_range(0, 127)), 1'($urandom_range(0, 4) != 0)});
   endtask

   // One new table entry: usually a plausible block inside the full-width
   // code space, sometimes a reversed one, sometimes arbitrary codes.
   task automatic queue_random_block(input logic [INDEX_W-1:0] idx, input int unsigned pct);
      logic [7:0]        lead;
      logic [CODE_W-1:0] lo;
      logic [CODE_W-1:0] hi;
      case ($urandom_range(0, 7))
         0: begin
            lo = CODE_W'($urandom_range(0, 65535));
            hi = CODE_W'($urandom_range(0, 65535));
         end
         1: begin
            hi = CODE_W'($urandom_range(16'h8000, 16'hFCFF));
            lo = hi + 16'($urandom_range(1, 64));
         end
         default: begin
            lead = ($urandom_range(0, 1) != 0) ?
                   8'($urandom_range(LEAD_LO_FIRST, LEAD_LO_LAST)) :
                   8'($urandom_range(LEAD_HI_FIRST, LEAD_HI_LAST));
            lo = {lead, 8'($urandom_range(0, 255))};
            hi = lo + 16'($urandom_range(0, 150));
         end
      endcase
      queue_block_write(idx, lo, hi, pct);
   endtask

   // Fills the whole table once, so no later scan can reach an entry that
   // was never written. Blocks run upward through the full-width code space.
   task automatic queue_table_layout(input int unsigned pct);
      int unsigned       cursor;
      int unsigned       len;
      int unsigned       j;
      logic [CODE_W-1:0] lo;
      logic [CODE_W-1:0] hi;
      cursor = 16'h8140;
      for (j = 0; j < MAX_BLOCKS; j++) begin
         len = $urandom_range(1, 96);
         case ($urandom_range(0, 15))
            0: begin
               lo = CODE_W'($urandom_range(0, 65535));
               hi = CODE_W'($urandom_range(0, 65535));
            end
            1: begin
               lo = CODE_W'(cursor + len);
               hi = CODE_W'(cursor);
            end
            default: begin
               lo = CODE_W'(cursor);
               hi = CODE_W'(cursor + len - 1);
            end
         endcase
         queue_block_write(INDEX_W'(j), lo, hi, pct);
         cursor = cursor + len + $urandom_range(0, 8);
         // Skip the half-width lead bytes and wrap before 0xFD.
         if (cursor[15:8] >= 8'hA0 && cursor[15:8] < LEAD_HI_FIRST) cursor = 16'hE040;
         else if (cursor[15:8] > LEAD_HI_LAST) cursor = 16'h8140;
      end
   endtask

   // Lookup codes for the random part: most aim inside a block that the scan
   // will reach, the rest are stray full-width codes, half-width codes and
   // arbitrary values.
   function automatic logic [CODE_W-1:0] pick_code();
      logic [7:0]  lead;
      int unsigned sel;
      int unsigned j;
      int unsigned lo;
      int unsigned hi;
      sel = $urandom_range(0, 99);
      if (sel < 55 && plan_count != 0) begin
         j = $urandom_range(0, plan_count - 1);
         lo = plan_blocks[j].first_code;
         hi = plan_blocks[j].last_code;
         if (lo <= hi) return CODE_W'(lo + $urandom_range(0, hi - lo));
      end
      if (sel < 70) begin
         lead = ($urandom_range(0, 1) != 0) ?
                8'($urandom_range(LEAD_LO_FIRST, LEAD_LO_LAST)) :
                8'($urandom_range(LEAD_HI_FIRST, LEAD_HI_LAST));
         return {lead, 8'($urandom_range(0, 255))};
      end
      if (sel < 90) begin
         do lead = 8'($urandom_range(0, 255)); while (is_kanji_lead(lead));
         return {lead, 8'($urandom_range(0, 255))};
      end
      return CODE_W'($urandom_range(0, 65535));
   endfunction

   // ------------------------------------------------------------------------
   // Driver. At each edge it first retires whatever beat the block took, then
   // picks what to present next. start and csr_valid get at most one
   // nonblocking assignment per edge, so a beat that follows another keeps
   // start high without a glitch.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic holding;
      logic start_n;
      logic csr_n;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         reg_full_w = 6'd16;
         reg_full_h = 6'd16;
         reg_half_w = 6'd8;
         reg_half_h = 6'd16;
         reg_block_count = '0;
         reg_full_present = 1'b0;
         reg_half_present = 1'b0;
         gap_left = 0;
         gap_rolled = 1'b0;
         draining = 1'b0;
         settle_left = 0;
      end else begin
         holding = 1'b0;
         // A command beat goes in when start is high and busy is low; the
         // prediction is made right here so it sees the state of that edge.
         if (start) begin
            if (busy) begin
               holding = 1'b1;
            end else if (cur_op.mode == MODE_WRITE) begin
               code_blocks[cur_op.block_index] = '{first_code: cur_op.range_start,
                                                   last_code:  cur_op.range_end};
               writes_taken++;
            end else begin
               expected_locs.push_back(locate_glyph(cur_op.char_code));
               lookups_taken++;
            end
         end
         if (csr_valid) begin
            if (!csr_ready) begin
               holding = 1'b1;
            end else begin
               case (cur_op.reg_index)
                  REG_FULL_WIDTH:   reg_full_w = cur_op.reg_data[DIM_W-1:0];
                  REG_FULL_HEIGHT:  reg_full_h = cur_op.reg_data[DIM_W-1:0];
                  REG_HALF_WIDTH:   reg_half_w = cur_op.reg_data[DIM_W-1:0];
                  REG_HALF_HEIGHT:  reg_half_h = cur_op.reg_data[DIM_W-1:0];
                  REG_BLOCK_COUNT:  reg_block_count = cur_op.reg_data;
                  REG_FULL_PRESENT: reg_full_present = cur_op.reg_data[0];
                  REG_HALF_PRESENT: reg_half_present = cur_op.reg_data[0];
                  default: ;
               endcase
               regs_taken++;
            end
         end
         if (!holding) begin
            start_n = 1'b0;
            csr_n = 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end else if (draining) begin
               // Wait for the scoreboard to empty, then let the block settle.
               if (expected_locs.size() != 0 || busy) settle_left = SETTLE_CYCLES;
               else if (settle_left != 0) settle_left--;
               else draining = 1'b0;
            end else if (op_q.size() == 0) begin
               stim_done = 1'b1;
            end else if (!gap_rolled && $urandom_range(0, 99) < op_q[0].gap_pct) begin
               // An idle burst of random length; this edge is its first.
               gap_rolled = 1'b1;
               gap_left = $urandom_range(0, 10);
            end else begin
               gap_rolled = 1'b0;
               cur_op = op_q.pop_front();
               case (cur_op.kind)
                  OP_CMD: begin
                     req_mode <= cur_op.mode;
                     req_block_index <= cur_op.block_index;
                     req_range_start <= cur_op.range_start;
                     req_range_end <= cur_op.range_end;
                     req_char_code <= cur_op.char_code;
                     start_n = 1'b1;
                  end
                  OP_CSR: begin
                     csr_index <= cur_op.reg_index;
                     csr_data <= cur_op.reg_data;
                     csr_n = 1'b1;
                  end
                  default: begin
                     draining = 1'b1;
                     settle_left = SETTLE_CYCLES;
                  end
               endcase
            end
            start <= start_n;
            csr_valid <= csr_n;
         end
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor. A result is held for exactly one cycle and cannot be stalled,
   // so every edge with rsp_valid high is a beat to check against the oldest
   // prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      glyph_loc_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_locs.size() == 0) begin
            $display("%0t ns: stray result, expected none, got found=%0b offset=0x%0h",
                     $time, rsp_found, rsp_glyph_offset);
            mismatches++;
         end else begin
            want = expected_locs.pop_front();
            if (want.found) located_seen++;
            if (want.is_full) full_seen++;
            compare_field("found", want.found, rsp_found);
            compare_field("is_full_width", want.is_full, rsp_is_full_width);
            compare_field("glyph_offset", want.offset, rsp_glyph_offset);
            compare_field("glyph_bytes", want.glyph_bytes, rsp_glyph_bytes);
            compare_field("advance_width", want.advance, rsp_advance_width);
         end
      end
   end

   // A run that hangs, or that leaves predictions unanswered, ends here.
   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("%0t ns: gave up after %0d cycles with %0d results outstanding",
               $time, cycle_count, expected_locs.size());
      $display("fontx2_glyph_locator_core: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus plan, built up front, followed by the end-of-run check.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned p;
      int unsigned k;
      int unsigned pct;
      plan_count = 0;

      // Straight out of reset both fonts are absent: lookups of either kind
      // miss but still report their class.
      queue_lookup(16'h0000, 0);
      queue_lookup(16'h8140, 0);

      // Write every table entry once, then overwrite the head of the table
      // with known blocks, a reversed one among them.
      queue_table_layout(20);
      queue_block_write(7'd0, 16'h8140, 16'h817E, 20);
      queue_block_write(7'd1, 16'h8180, 16'h81FC, 20);
      queue_block_write(7'd2, 16'h8300, 16'h82F0, 20);
      queue_block_write(7'd3, 16'h889F, 16'h88FC, 20);
      queue_block_write(7'd4, 16'hE040, 16'hE0FC, 20);
      queue_block_write(7'd5, 16'hFC40, 16'hFC4B, 20);

      // Default glyph sizes, six blocks, both fonts present.
      queue_setting(20, 8'd16, 8'd16, 8'd8, 8'd16, 8'd6, 8'd1, 8'd1);
      queue_lookup(16'h8140, 20);   // first code of the first block
      queue_lookup(16'h817E, 20);   // last code of the first block
      queue_lookup(16'h8180, 20);   // start of the second block
      queue_lookup(16'h88A0, 20);   // past the reversed block, counter wraps
      queue_lookup(16'hFC4B, 20);   // last code of the last block
      queue_lookup(16'hFC4C, 20);   // just past the last block
      queue_lookup(16'h813F, 20);   // just below the first block
      queue_lookup(16'h9FFF, 20);   // top of the low lead range, no block
      queue_lookup(16'hE000, 20);   // bottom of the high lead range, no block
      queue_lookup(16'h0000, 20);   // half-width extremes and lead edges
      queue_lookup(16'hFFFF, 20);
      queue_lookup(16'h7FFF, 20);
      queue_lookup(16'hA0A0, 20);
      queue_lookup(16'hDFFF, 20);
      queue_lookup(16'hFD00, 20);

      // Zero and oversized glyph dimensions with a count beyond the table.
      queue_setting(20, 8'd0, 8'd63, 8'd63, 8'd0, 8'd255, 8'd1, 8'd1);
      queue_lookup(16'h8140, 20);
      queue_lookup(16'h0041, 20);

      // Largest legal glyphs, one-pixel half glyphs, an empty table.
      queue_setting(20, 8'd32, 8'd32, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1);
      queue_lookup(16'h8140, 20);
      queue_lookup(16'hFFFF, 20);

      // Random phases: new settings, lookups aimed mostly at live blocks, and
      // a sprinkling of table rewrites. One phase pauses midway until every
      // result is home.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         pct = gap_plan[p];
         queue_random_setting(pct);
         for (k = 0; k < PHASE_BEATS; k++) begin
            if (p == 3 && k == PHASE_BEATS / 2) queue_drain();
            if ($urandom_range(0, 9) == 0)
               queue_random_block(INDEX_W'($urandom_range(0, MAX_BLOCKS - 1)), pct);
            else
               queue_lookup(pick_code(), pct);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (stim_done);
      while (expected_locs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d lookups (%0d located, %0d full-width) against %0d table writes",
               results_seen, located_seen, full_seen, writes_taken);
      $display("and %0d register writes across %0d settings.", regs_taken, RANDOM_PHASES + 3);
      if (mismatches == 0) begin
         $display("fontx2_glyph_locator_core: match");
      end else begin
         $display("fontx2_glyph_locator_core: mismatch");
      end
      $finish;
   end

endmodule
